[hw/rtl/tgt_pkg.sv]
`timescale 1ns / 1ps

package tgt_pkg;

	localparam int CAL_W     = 12;
	localparam int POS_W     = 12;
	localparam int OUT_POS_W = 9;
	localparam int TIME_W    = 32;
	localparam int CROWN_W   = 32;
	localparam int DATA_W    = 32;
	localparam int ADDR_W    = 5;
	localparam int CNT_NIB_W = 4;

	localparam int SCREEN_WIDTH  = 466;
	localparam int SCREEN_HEIGHT = 466;
	localparam int SCREEN_MAX    = (SCREEN_WIDTH > SCREEN_HEIGHT) ? SCREEN_WIDTH : SCREEN_HEIGHT;
	localparam int SIZE_W        = $clog2(SCREEN_MAX + 1);
	localparam int NUM_W         = CAL_W + SIZE_W;
	localparam int STEP_W        = $clog2(NUM_W + 1);

	localparam logic [TIME_W-1:0] SWIPE_MIN_MS = TIME_W'(100);
	localparam logic [TIME_W-1:0] SWIPE_MAX_MS = TIME_W'(500);

	localparam logic REQ_CLEAR = 1'b1;

	typedef enum logic [2:0] {
		REG_CAL_MIN_X  = 3'd0,
		REG_CAL_MAX_X  = 3'd1,
		REG_CAL_MIN_Y  = 3'd2,
		REG_CAL_MAX_Y  = 3'd3,
		REG_LONG_PRESS = 3'd4,
		REG_TAP        = 3'd5,
		REG_MOVE_THR   = 3'd6,
		REG_SWIPE_DIST = 3'd7
	} cfg_reg_t;

	typedef enum logic [3:0] {
		EV_NONE    = 4'd0,
		EV_PRESS   = 4'd1,
		EV_RELEASE = 4'd2,
		EV_TAP     = 4'd3,
		EV_LONG    = 4'd4,
		EV_MOVE    = 4'd5,
		EV_LEFT    = 4'd6,
		EV_RIGHT   = 4'd7,
		EV_UP      = 4'd8,
		EV_DOWN    = 4'd9
	} ev_t;

	typedef enum logic [1:0] {
		SEQ_IDLE,
		SEQ_MAP,
		SEQ_EVAL,
		SEQ_COMMIT
	} seq_state_t;

	typedef struct packed {
		logic [CAL_W-1:0] cal_min_x;
		logic [CAL_W-1:0] cal_max_x;
		logic [CAL_W-1:0] cal_min_y;
		logic [CAL_W-1:0] cal_max_y;
		logic [15:0]      long_press_ms;
		logic [15:0]      tap_ms;
		logic [7:0]       move_threshold;
		logic [9:0]       swipe_distance;
	} cfg_t;

	typedef struct packed {
		logic                 req_type;
		logic                 int_active;
		logic                 data_ok;
		logic [CNT_NIB_W-1:0] count;
		logic [TIME_W-1:0]    now_ms;
	} item_t;

	typedef struct packed {
		ev_t                   ev;
		logic [OUT_POS_W-1:0]  pos_x;
		logic [OUT_POS_W-1:0]  pos_y;
		logic [OUT_POS_W-1:0]  from_x;
		logic [OUT_POS_W-1:0]  from_y;
		logic [OUT_POS_W-1:0]  to_x;
		logic [OUT_POS_W-1:0]  to_y;
		logic [TIME_W-1:0]     hold;
		logic                  valid;
		logic [CROWN_W-1:0]    crown;
	} res_t;

	typedef struct packed {
		logic div_start;
		logic eval_en;
		logic commit_en;
	} seq_ctl_t;

endpackage

[hw/rtl/tgt_axis_div.sv]
`timescale 1ns / 1ps

module tgt_axis_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic                       axis_sel,
	input  logic [tgt_pkg::CAL_W-1:0]  raw,
	input  logic [tgt_pkg::CAL_W-1:0]  lo,
	input  logic [tgt_pkg::CAL_W-1:0]  hi,
	output logic                       done,
	output logic [tgt_pkg::POS_W-1:0]  coord
);

	localparam int CAL_W  = tgt_pkg::CAL_W;
	localparam int NUM_W  = tgt_pkg::NUM_W;
	localparam int SIZE_W = tgt_pkg::SIZE_W;
	localparam int STEP_W = tgt_pkg::STEP_W;

	logic [CAL_W:0]   diff_d;
	logic [CAL_W:0]   den_d;
	logic [CAL_W:0]   diff_neg;
	logic [CAL_W:0]   den_neg;
	logic [SIZE_W-1:0] size_d;

	logic [CAL_W-1:0]  num_mag_s1;
	logic [CAL_W-1:0]  den_mag_s1;
	logic [SIZE_W-1:0] size_s1;
	logic              flip_s1;
	logic              zden_s1;
	logic              load_s1;

	logic [NUM_W-1:0]  quo_q;
	logic [CAL_W-1:0]  rem_q;
	logic [STEP_W-1:0] cnt_q;
	logic              done_q;

	logic [CAL_W:0]    trial;
	logic              qbit;
	logic [NUM_W-1:0]  limit;

	assign size_d   = axis_sel ? SIZE_W'(tgt_pkg::SCREEN_HEIGHT) : SIZE_W'(tgt_pkg::SCREEN_WIDTH);
	assign diff_d   = {1'b0, raw} - {1'b0, lo};
	assign den_d    = {1'b0, hi} - {1'b0, lo};
	assign diff_neg = (CAL_W + 1)'(0) - diff_d;
	assign den_neg  = (CAL_W + 1)'(0) - den_d;

	always_ff @(posedge clk) begin
		if (start) begin
			num_mag_s1 <= diff_d[CAL_W] ? diff_neg[CAL_W-1:0] : diff_d[CAL_W-1:0];
			den_mag_s1 <= den_d[CAL_W] ? den_neg[CAL_W-1:0] : den_d[CAL_W-1:0];
			size_s1    <= size_d;
			flip_s1    <= diff_d[CAL_W] ^ den_d[CAL_W];
			zden_s1    <= (den_d == '0);
		end
	end

	assign trial = {rem_q, quo_q[NUM_W-1]};
	assign qbit  = (trial >= {1'b0, den_mag_s1});

	always_ff @(posedge clk) begin
		if (load_s1) begin
			quo_q <= NUM_W'(num_mag_s1) * NUM_W'(size_s1);
			rem_q <= '0;
		end else if (cnt_q != '0) begin
			quo_q <= {quo_q[NUM_W-2:0], qbit};
			rem_q <= qbit ? CAL_W'(trial - {1'b0, den_mag_s1}) : trial[CAL_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_s1 <= 1'b0;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			load_s1 <= start;
			done_q  <= (cnt_q == STEP_W'(1));
			if (load_s1) begin
				cnt_q <= STEP_W'(NUM_W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - STEP_W'(1);
			end
		end
	end

	assign limit = NUM_W'(size_s1) - NUM_W'(1);
	assign done  = done_q;

	always_comb begin
		if (flip_s1 || zden_s1) begin
			coord = '0;
		end else if (quo_q > limit) begin
			coord = limit[tgt_pkg::POS_W-1:0];
		end else begin
			coord = quo_q[tgt_pkg::POS_W-1:0];
		end
	end

endmodule

[hw/rtl/tgt_tracker.sv]
`timescale 1ns / 1ps

module tgt_tracker (
	input  logic                      clk,
	input  logic                      arst_n,
	input  tgt_pkg::cfg_t             cfg,
	input  tgt_pkg::item_t            item,
	input  logic [tgt_pkg::POS_W-1:0] cx,
	input  logic [tgt_pkg::POS_W-1:0] cy,
	input  logic                      eval_en,
	input  logic                      commit_en,
	output tgt_pkg::res_t             res
);

	localparam int POS_W   = tgt_pkg::POS_W;
	localparam int OP_W    = tgt_pkg::OUT_POS_W;
	localparam int TIME_W  = tgt_pkg::TIME_W;
	localparam int CROWN_W = tgt_pkg::CROWN_W;

	logic               pressed_q;
	logic [POS_W-1:0]   last_col_q;
	logic [POS_W-1:0]   last_row_q;
	logic [TIME_W-1:0]  press_start_q;
	logic [CROWN_W-1:0] crown_q;

	logic [TIME_W-1:0]  dur_s1;
	logic [POS_W:0]     dx_s1;
	logic [POS_W:0]     dy_s1;
	logic [POS_W-1:0]   ax_s1;
	logic [POS_W-1:0]   ay_s1;

	logic [POS_W:0]     dx_d;
	logic [POS_W:0]     dy_d;
	logic [POS_W:0]     dx_neg;
	logic [POS_W:0]     dy_neg;

	logic               pressed_d;
	logic [POS_W-1:0]   last_col_d;
	logic [POS_W-1:0]   last_row_d;
	logic [TIME_W-1:0]  press_start_d;
	logic [CROWN_W-1:0] crown_d;

	logic               move_hit;
	logic               swipe_win;

	assign dx_d   = {1'b0, cx} - {1'b0, last_col_q};
	assign dy_d   = {1'b0, cy} - {1'b0, last_row_q};
	assign dx_neg = (POS_W + 1)'(0) - dx_d;
	assign dy_neg = (POS_W + 1)'(0) - dy_d;

	always_ff @(posedge clk) begin
		if (eval_en) begin
			dur_s1 <= item.now_ms - press_start_q;
			dx_s1  <= dx_d;
			dy_s1  <= dy_d;
			ax_s1  <= dx_d[POS_W] ? dx_neg[POS_W-1:0] : dx_d[POS_W-1:0];
			ay_s1  <= dy_d[POS_W] ? dy_neg[POS_W-1:0] : dy_d[POS_W-1:0];
		end
	end

	assign move_hit  = (ax_s1 > POS_W'(cfg.move_threshold)) ||
	                   (ay_s1 > POS_W'(cfg.move_threshold));
	assign swipe_win = (dur_s1 > tgt_pkg::SWIPE_MIN_MS) && (dur_s1 < tgt_pkg::SWIPE_MAX_MS);

	always_comb begin
		res           = '0;
		res.ev        = tgt_pkg::EV_NONE;
		pressed_d     = pressed_q;
		last_col_d    = last_col_q;
		last_row_d    = last_row_q;
		press_start_d = press_start_q;
		crown_d       = crown_q;
		if (item.req_type == tgt_pkg::REQ_CLEAR) begin
			crown_d = '0;
		end else if (item.int_active && item.data_ok) begin
			if (item.count == '0) begin
				if (pressed_q) begin
					pressed_d = 1'b0;
					if (dur_s1 > TIME_W'(cfg.long_press_ms)) begin
						res.ev = tgt_pkg::EV_LONG;
					end else if (dur_s1 < TIME_W'(cfg.tap_ms)) begin
						res.ev = tgt_pkg::EV_TAP;
					end else begin
						res.ev = tgt_pkg::EV_RELEASE;
					end
					res.pos_x  = last_col_q[OP_W-1:0];
					res.from_x = last_col_q[OP_W-1:0];
					res.to_x   = last_col_q[OP_W-1:0];
					res.pos_y  = last_row_q[OP_W-1:0];
					res.from_y = last_row_q[OP_W-1:0];
					res.to_y   = last_row_q[OP_W-1:0];
					res.hold   = dur_s1;
					res.valid  = 1'b1;
				end
			end else if (!pressed_q) begin
				pressed_d     = 1'b1;
				press_start_d = item.now_ms;
				last_col_d    = cx;
				last_row_d    = cy;
				res.ev        = tgt_pkg::EV_PRESS;
				res.pos_x     = cx[OP_W-1:0];
				res.from_x    = cx[OP_W-1:0];
				res.pos_y     = cy[OP_W-1:0];
				res.from_y    = cy[OP_W-1:0];
				res.valid     = 1'b1;
			end else if (move_hit) begin
				res.ev     = tgt_pkg::EV_MOVE;
				res.pos_x  = cx[OP_W-1:0];
				res.to_x   = cx[OP_W-1:0];
				res.pos_y  = cy[OP_W-1:0];
				res.to_y   = cy[OP_W-1:0];
				res.from_x = last_col_q[OP_W-1:0];
				res.from_y = last_row_q[OP_W-1:0];
				res.valid  = 1'b1;
				crown_d    = crown_q + {{(CROWN_W - POS_W - 1){dy_s1[POS_W]}}, dy_s1};
				if (swipe_win) begin
					if ((ax_s1 > ay_s1) && (ax_s1 > POS_W'(cfg.swipe_distance))) begin
						res.ev = dx_s1[POS_W] ? tgt_pkg::EV_LEFT : tgt_pkg::EV_RIGHT;
					end else if ((ay_s1 > ax_s1) && (ay_s1 > POS_W'(cfg.swipe_distance))) begin
						res.ev = dy_s1[POS_W] ? tgt_pkg::EV_UP : tgt_pkg::EV_DOWN;
					end
				end
				last_col_d = cx;
				last_row_d = cy;
			end
		end
		res.crown = crown_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pressed_q     <= 1'b0;
			last_col_q    <= '0;
			last_row_q    <= '0;
			press_start_q <= '0;
			crown_q       <= '0;
		end else if (commit_en) begin
			pressed_q     <= pressed_d;
			last_col_q    <= last_col_d;
			last_row_q    <= last_row_d;
			press_start_q <= press_start_d;
			crown_q       <= crown_d;
		end
	end

endmodule

[hw/rtl/touch_gesture_tracker.sv]
`timescale 1ns / 1ps

// Channel   Handshake                      Payload
// item      item_valid / item_ready        req_type .. now_ms
// result    result_valid / result_ready    event_code .. crown_value
// config    APB write (psel, penable)      paddr, pwdata / prdata
//
// Every item passes from transfer through the map, eval and commit states before its result is registered.
// The next transfer is taken only after the commit, so the block handles one item at a time.
// The map phase ends when the two coordinate dividers finish; they produce one quotient bit per cycle.
// Reset restores the calibration and timing registers and clears the touch state.
// A held result does not block the next transfer; only a second finished result waits for it.

module touch_gesture_tracker (
	input  logic                             clk,
	input  logic                             arst_n,

	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [tgt_pkg::ADDR_W-1:0]       paddr,
	input  logic [tgt_pkg::DATA_W-1:0]       pwdata,
	output logic [tgt_pkg::DATA_W-1:0]       prdata,
	output logic                             pready,

	input  logic                             item_valid,
	output logic                             item_ready,
	input  logic                             req_type,
	input  logic                             int_active,
	input  logic                             data_ok,
	input  logic [7:0]                       status_byte,
	input  logic [7:0]                       x_high_byte,
	input  logic [7:0]                       x_low_byte,
	input  logic [7:0]                       y_high_byte,
	input  logic [7:0]                       y_low_byte,
	input  logic [tgt_pkg::TIME_W-1:0]       now_ms,

	output logic                             result_valid,
	input  logic                             result_ready,
	output logic [3:0]                       event_code,
	output logic [tgt_pkg::OUT_POS_W-1:0]    pos_x,
	output logic [tgt_pkg::OUT_POS_W-1:0]    pos_y,
	output logic [tgt_pkg::OUT_POS_W-1:0]    from_x,
	output logic [tgt_pkg::OUT_POS_W-1:0]    from_y,
	output logic [tgt_pkg::OUT_POS_W-1:0]    to_x,
	output logic [tgt_pkg::OUT_POS_W-1:0]    to_y,
	output logic [tgt_pkg::TIME_W-1:0]       hold_ms,
	output logic                             event_valid,
	output logic signed [tgt_pkg::CROWN_W-1:0] crown_value
);

	localparam int CAL_W  = tgt_pkg::CAL_W;
	localparam int DATA_W = tgt_pkg::DATA_W;

	tgt_pkg::cfg_t       cfg_q;
	tgt_pkg::item_t      item_q;
	tgt_pkg::res_t       res_d;
	tgt_pkg::res_t       res_q;
	tgt_pkg::seq_state_t state_q;
	tgt_pkg::seq_state_t state_d;
	tgt_pkg::seq_ctl_t   ctl;
	tgt_pkg::cfg_reg_t   reg_sel;

	logic                result_valid_q;
	logic                cfg_write;
	logic                item_xfer;
	logic                x_done;
	logic                y_done;
	logic [tgt_pkg::POS_W-1:0] cx;
	logic [tgt_pkg::POS_W-1:0] cy;

	assign pready    = 1'b1;
	assign reg_sel   = tgt_pkg::cfg_reg_t'(paddr[4:2]);
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.cal_min_x      <= CAL_W'(100);
			cfg_q.cal_max_x      <= CAL_W'(3900);
			cfg_q.cal_min_y      <= CAL_W'(100);
			cfg_q.cal_max_y      <= CAL_W'(3900);
			cfg_q.long_press_ms  <= 16'd800;
			cfg_q.tap_ms         <= 16'd200;
			cfg_q.move_threshold <= 8'd5;
			cfg_q.swipe_distance <= 10'd50;
		end else if (cfg_write) begin
			unique case (reg_sel)
				tgt_pkg::REG_CAL_MIN_X:  cfg_q.cal_min_x      <= pwdata[CAL_W-1:0];
				tgt_pkg::REG_CAL_MAX_X:  cfg_q.cal_max_x      <= pwdata[CAL_W-1:0];
				tgt_pkg::REG_CAL_MIN_Y:  cfg_q.cal_min_y      <= pwdata[CAL_W-1:0];
				tgt_pkg::REG_CAL_MAX_Y:  cfg_q.cal_max_y      <= pwdata[CAL_W-1:0];
				tgt_pkg::REG_LONG_PRESS: cfg_q.long_press_ms  <= pwdata[15:0];
				tgt_pkg::REG_TAP:        cfg_q.tap_ms         <= pwdata[15:0];
				tgt_pkg::REG_MOVE_THR:   cfg_q.move_threshold <= pwdata[7:0];
				tgt_pkg::REG_SWIPE_DIST: cfg_q.swipe_distance <= pwdata[9:0];
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			tgt_pkg::REG_CAL_MIN_X:  prdata = DATA_W'(cfg_q.cal_min_x);
			tgt_pkg::REG_CAL_MAX_X:  prdata = DATA_W'(cfg_q.cal_max_x);
			tgt_pkg::REG_CAL_MIN_Y:  prdata = DATA_W'(cfg_q.cal_min_y);
			tgt_pkg::REG_CAL_MAX_Y:  prdata = DATA_W'(cfg_q.cal_max_y);
			tgt_pkg::REG_LONG_PRESS: prdata = DATA_W'(cfg_q.long_press_ms);
			tgt_pkg::REG_TAP:        prdata = DATA_W'(cfg_q.tap_ms);
			tgt_pkg::REG_MOVE_THR:   prdata = DATA_W'(cfg_q.move_threshold);
			tgt_pkg::REG_SWIPE_DIST: prdata = DATA_W'(cfg_q.swipe_distance);
		endcase
	end

	assign item_xfer = item_valid && item_ready;

	always_ff @(posedge clk) begin
		if (item_xfer) begin
			item_q.req_type   <= req_type;
			item_q.int_active <= int_active;
			item_q.data_ok    <= data_ok;
			item_q.count      <= status_byte[3:0];
			item_q.now_ms     <= now_ms;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			tgt_pkg::SEQ_IDLE: begin
				if (item_valid) begin
					state_d = tgt_pkg::SEQ_MAP;
				end
			end
			tgt_pkg::SEQ_MAP: begin
				if (x_done) begin
					state_d = tgt_pkg::SEQ_EVAL;
				end
			end
			tgt_pkg::SEQ_EVAL: begin
				state_d = tgt_pkg::SEQ_COMMIT;
			end
			tgt_pkg::SEQ_COMMIT: begin
				if (!result_valid_q || result_ready) begin
					state_d = tgt_pkg::SEQ_IDLE;
				end
			end
		endcase
	end

	always_comb begin
		item_ready    = 1'b0;
		ctl           = '0;
		unique case (state_q)
			tgt_pkg::SEQ_IDLE: begin
				item_ready    = 1'b1;
				ctl.div_start = item_valid;
			end
			tgt_pkg::SEQ_MAP: begin
			end
			tgt_pkg::SEQ_EVAL: begin
				ctl.eval_en = 1'b1;
			end
			tgt_pkg::SEQ_COMMIT: begin
				ctl.commit_en = !result_valid_q || result_ready;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tgt_pkg::SEQ_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	tgt_axis_div u_div_x (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (ctl.div_start),
		.axis_sel (1'b0),
		.raw      ({x_high_byte[3:0], x_low_byte}),
		.lo       (cfg_q.cal_min_x),
		.hi       (cfg_q.cal_max_x),
		.done     (x_done),
		.coord    (cx)
	);

	tgt_axis_div u_div_y (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (ctl.div_start),
		.axis_sel (1'b1),
		.raw      ({y_high_byte[3:0], y_low_byte}),
		.lo       (cfg_q.cal_min_y),
		.hi       (cfg_q.cal_max_y),
		.done     (y_done),
		.coord    (cy)
	);

	tgt_tracker u_tracker (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.item      (item_q),
		.cx        (cx),
		.cy        (cy),
		.eval_en   (ctl.eval_en),
		.commit_en (ctl.commit_en),
		.res       (res_d)
	);

	always_ff @(posedge clk) begin
		if (ctl.commit_en) begin
			res_q <= res_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (ctl.commit_en) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	assign result_valid = result_valid_q;
	assign event_code   = res_q.ev;
	assign pos_x        = res_q.pos_x;
	assign pos_y        = res_q.pos_y;
	assign from_x       = res_q.from_x;
	assign from_y       = res_q.from_y;
	assign to_x         = res_q.to_x;
	assign to_y         = res_q.to_y;
	assign hold_ms      = res_q.hold;
	assign event_valid  = res_q.valid;
	assign crown_value  = res_q.crown;

	a_div_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		x_done == y_done)
		else $error("coordinate dividers out of step");

	a_done_in_map: assert property (@(posedge clk) disable iff (!arst_n)
		x_done |-> state_q == tgt_pkg::SEQ_MAP)
		else $error("divider finished outside the map phase");

	a_xfer_starts_map: assert property (@(posedge clk) disable iff (!arst_n)
		item_xfer |=> state_q == tgt_pkg::SEQ_MAP)
		else $error("transfer did not start the map phase");

	a_result_from_commit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid_q) |-> $past(state_q) == tgt_pkg::SEQ_COMMIT)
		else $error("result appeared without a commit");

endmodule
